FILE: hw/rtl/rtmu_pkg.sv
package rtmu_pkg;

	localparam int MAX_RANGES = 256;
	localparam int VALUE_BITS = 48;
	localparam int COUNT_BITS = 32;
	localparam int ADDR_W = $clog2(MAX_RANGES);
	localparam int CNT_W = $clog2(MAX_RANGES + 1);
	localparam int TOT_W = VALUE_BITS + 1;

	localparam int IN_W = 3 * VALUE_BITS;
	localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W = 2 + 1 + COUNT_BITS + TOT_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_QUERY = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;

	typedef struct packed {
		logic [TOT_W-1:0] covered_total;
		logic [COUNT_BITS-1:0] hit_count;
		logic hit;
		logic [1:0] status;
	} result_t;

endpackage

FILE: hw/rtl/range_table_match_and_union.sv
// Load: the result is registered in the cycle after accept. Query: one range
// compare per cycle, each stored range read through the table port.
// Finish: one pass over the table per covered piece plus one, each piece
// ending at one stored range end, so at most ranges + 1 passes.
// One transaction at a time. arst_n clears the range count, hit counter and
// handshake; the table keeps its contents and needs no clearing pass.
module range_table_match_and_union (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [rtmu_pkg::IN_TDATA_W-1:0] s_tdata, // range_low, range_high, query_value
	input logic [1:0] s_tuser, // action
	output logic m_tvalid,
	input logic m_tready,
	output logic [rtmu_pkg::OUT_TDATA_W-1:0] m_tdata // status, hit, hit_count, covered_total
);

	localparam int VB = rtmu_pkg::VALUE_BITS;
	localparam int AW = rtmu_pkg::ADDR_W;
	localparam int CW = rtmu_pkg::CNT_W;
	localparam int TW = rtmu_pkg::TOT_W;
	localparam int KB = rtmu_pkg::COUNT_BITS;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_QSCAN = 2'd1;
	localparam logic [1:0] S_USCAN = 2'd2;

	logic [1:0] state_q;
	logic [2*VB-1:0] mem_q [rtmu_pkg::MAX_RANGES];
	logic [2*VB-1:0] rd_q;
	logic [CW-1:0] cnt_q, idx_q;
	logic pend_q;
	logic [KB-1:0] hits_q;
	logic [VB-1:0] qv_q, best_a_q, best_b_q;
	logic [TW-1:0] f_q, total_q;
	logic hit_q, found_q;
	rtmu_pkg::result_t res_q;
	logic mv_q;

	logic [VB-1:0] in_lo, in_hi, in_q, rd_s, rd_e, eff_s;
	logic accept, issue, pass_end, cand, better;
	logic [TW-1:0] span;

	assign in_lo = s_tdata[VB-1:0];
	assign in_hi = s_tdata[2*VB-1:VB];
	assign in_q = s_tdata[3*VB-1:2*VB];
	assign s_tready = (state_q == S_IDLE) && !mv_q;
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = mv_q;
	assign m_tdata = {{(rtmu_pkg::OUT_TDATA_W - rtmu_pkg::OUT_W){1'b0}}, res_q};

	assign rd_s = rd_q[VB-1:0];
	assign rd_e = rd_q[2*VB-1:VB];
	assign issue = idx_q < cnt_q;
	assign pass_end = !pend_q && (idx_q == cnt_q);
	assign eff_s = ({1'b0, rd_s} < f_q) ? f_q[VB-1:0] : rd_s;
	assign cand = pend_q && ({1'b0, rd_e} >= f_q);
	assign better = !found_q || (eff_s < best_a_q) ||
		((eff_s == best_a_q) && (rd_e > best_b_q));
	assign span = {1'b0, best_b_q} - {1'b0, best_a_q} + TW'(1);

	always_ff @(posedge clk) begin
		if (accept && s_tuser == rtmu_pkg::ACT_LOAD && in_lo <= in_hi &&
			cnt_q < CW'(rtmu_pkg::MAX_RANGES)) begin
			mem_q[cnt_q[AW-1:0]] <= {in_hi, in_lo};
		end
		if (issue) begin
			rd_q <= mem_q[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			hits_q <= '0;
			mv_q <= 1'b0;
			idx_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (mv_q && m_tready) begin
				mv_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						pend_q <= 1'b0;
						qv_q <= in_q;
						hit_q <= 1'b0;
						found_q <= 1'b0;
						f_q <= '0;
						total_q <= '0;
						res_q <= '0;
						res_q.hit_count <= hits_q;
						unique case (s_tuser)
							rtmu_pkg::ACT_LOAD: begin
								mv_q <= 1'b1;
								if (in_lo > in_hi) begin
									res_q.status <= rtmu_pkg::ST_ORDER;
								end else if (cnt_q >= CW'(rtmu_pkg::MAX_RANGES)) begin
									res_q.status <= rtmu_pkg::ST_FULL;
								end else begin
									cnt_q <= cnt_q + CW'(1);
								end
							end
							rtmu_pkg::ACT_QUERY: state_q <= S_QSCAN;
							rtmu_pkg::ACT_FINISH: state_q <= S_USCAN;
							default: mv_q <= 1'b1;
						endcase
					end
				end
				S_QSCAN: begin
					if (pend_q && rd_s <= qv_q && qv_q <= rd_e) begin
						hit_q <= 1'b1;
					end
					idx_q <= issue ? idx_q + CW'(1) : idx_q;
					pend_q <= issue;
					if (pass_end) begin
						state_q <= S_IDLE;
						mv_q <= 1'b1;
						res_q.hit <= hit_q;
						if (hit_q && hits_q != {KB{1'b1}}) begin
							hits_q <= hits_q + KB'(1);
							res_q.hit_count <= hits_q + KB'(1);
						end
					end
				end
				S_USCAN: begin
					if (cand && better) begin
						found_q <= 1'b1;
						if (!found_q || eff_s < best_a_q) begin
							best_a_q <= eff_s;
						end
						best_b_q <= rd_e;
					end
					idx_q <= issue ? idx_q + CW'(1) : idx_q;
					pend_q <= issue;
					if (pass_end) begin
						if (found_q) begin
							total_q <= total_q + span;
							f_q <= {1'b0, best_b_q} + TW'(1);
							found_q <= 1'b0;
							idx_q <= '0;
						end else begin
							state_q <= S_IDLE;
							mv_q <= 1'b1;
							res_q.covered_total <= total_q;
							cnt_q <= '0;
							hits_q <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/rtmu_checker.sv
module rtmu_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [rtmu_pkg::OUT_TDATA_W-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input taken while a result waits");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transaction taken before result");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[2] && m_tdata[1:0] != rtmu_pkg::ST_OK))
		else $error("hit reported with load status");

endmodule

bind range_table_match_and_union rtmu_checker u_rtmu_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
